FILE: src/cvfa_pkg.sv
`timescale 1ns / 1ps

package cvfa_pkg;

	// Fixed field widths
	localparam int VOL_BITS = 64;
	localparam int IDX_BITS = 10;

	// Half of the divisor six, added so the quotient rounds to nearest
	localparam int ROUND_BIAS = 3;

	typedef logic signed [VOL_BITS-1:0] vol_t;

	localparam vol_t VOL_MAX = {1'b0, {(VOL_BITS-1){1'b1}}};
	localparam vol_t VOL_MIN = {1'b1, {(VOL_BITS-1){1'b0}}};

	// Sequencer states
	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_MUL   = 9'b000000100,
		ST_DIV   = 9'b000001000,
		ST_RD_L  = 9'b000010000,
		ST_UP_L  = 9'b000100000,
		ST_RD_R  = 9'b001000000,
		ST_UP_R  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	// Passes through the shared multiplier, in issue order
	typedef enum logic [3:0] {
		MS_DA0_P,
		MS_DA0_N,
		MS_DA1_P,
		MS_DA1_N,
		MS_DA2_P,
		MS_DA2_N,
		MS_VOL,
		MS_DOT0,
		MS_DOT1,
		MS_DOT2,
		MS_LAST
	} mul_step_t;

endpackage

FILE: src/cvfa_div6.sv
`timescale 1ns / 1ps

// Unsigned divide by six: halve, then divide by three through multiplication by the
// inverse of three modulo 2^NW, built from one shift-and-add pass a cycle. The top two
// bits of the product tell the remainder mod three, and one subtract removes it.
module cvfa_div6 #(
	parameter int WIDTH = 53
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);
	// Even working width, at least two bits above the halved dividend for the remainder tag
	localparam int NW    = 2 * ((WIDTH + 2) / 2);
	localparam int NPASS = $clog2(NW) - 1;
	localparam int CW    = $clog2(NPASS + 1);
	// Inverse of three and twice it, modulo 2^NW
	localparam logic [NW-1:0] INV3   = {(NW/2){2'b10}} + NW'(1);
	localparam logic [NW-1:0] INV3X2 = {(NW/2){2'b01}} + NW'(1);
	// Remainder tags in the top two bits of the product
	localparam logic [1:0] TAG_REM1 = 2'b10;
	localparam logic [1:0] TAG_REM2 = 2'b01;

	logic [NW-1:0] v_q;
	logic [NW-1:0] step_w;
	logic [NW-1:0] corr;
	logic [NW-1:0] quot_w;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	// One pass: v + (v << 2^(pass+1))
	assign step_w = v_q + (v_q << (32'd2 << cnt_q));

	// Remove the remainder picked out by the tag
	always_comb begin
		case (v_q[NW-1:NW-2])
			TAG_REM1: corr = INV3;
			TAG_REM2: corr = INV3X2;
			default:  corr = '0;
		endcase
	end
	assign quot_w = v_q - corr;

	// Control: NPASS passes, then a negate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= CW'(cnt_q + 1'b1);
				if (cnt_q == CW'(NPASS)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= NW'(dividend[WIDTH-1:1]);
		end else if (run_q) begin
			v_q <= (cnt_q == CW'(NPASS)) ? -v_q : step_w;
		end
	end

	assign done     = done_q;
	assign quotient = quot_w[WIDTH-1:0];

endmodule

FILE: src/cell_volume_facet_accumulator.sv
`timescale 1ns / 1ps

// Cell volume accumulator: each word is one facet triangle (face center and the two nodes of
// a face edge, plus the face normal). dA = (center-node0) x (center-node1) and
// dV = (sum of the three x coordinates) * dA.x / 6, rounded to nearest, ties away from zero;
// dV goes with the sign of dA . normal into the left cell and against it into the right cell
// (left only for boundary facets), saturating to Q40.24. After reset the block clears its
// volume store, one entry a cycle, and holds busy high until every entry is cleared.
// Raise start while busy is low to hand over a word; busy then stays high until the result
// is out. The result is held on left_volume/right_volume until the next facet updates it,
// marked by done for exactly one cycle; the receiver cannot stall it. A facet runs through
// ten passes of one shared multiplier, a divide by six made of NPASS shift-and-add passes,
// where NPASS = ceil(log2(3*COORD_BITS + 6)) - 1, plus a negate and a fixup subtract, and a
// read-modify-write of the volume store, which has one read and one write port, for each
// cell (the left cell only for a boundary facet or an out-of-range right cell).
module cell_volume_facet_accumulator #(
	parameter int CELL_COUNT = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	output logic                           done,
	input  logic                           is_boundary,
	input  logic [cvfa_pkg::IDX_BITS-1:0]  left_cell,
	input  logic [cvfa_pkg::IDX_BITS-1:0]  right_cell,
	input  logic [3*COORD_BITS-1:0]        face_center,
	input  logic [3*COORD_BITS-1:0]        node0_pos,
	input  logic [3*COORD_BITS-1:0]        node1_pos,
	input  logic [3*COORD_BITS-1:0]        face_normal,
	output cvfa_pkg::vol_t                 left_volume,
	output cvfa_pkg::vol_t                 right_volume
);
	import cvfa_pkg::*;

	localparam int W    = COORD_BITS;
	localparam int AW   = $clog2(CELL_COUNT);
	localparam int DIFW = W + 1;
	localparam int SUMW = W + 2;
	localparam int DAW  = 2 * W + 3;
	localparam int PW   = 3 * W + 5;

	state_t    state_q;
	mul_step_t step_q, cap_q;
	logic      cap_v_q;
	logic [AW-1:0] clr_q;

	// Latched facet
	logic                bnd_q;
	logic [IDX_BITS-1:0] left_q, right_q;
	logic signed [DIFW-1:0] a_q [3];
	logic signed [DIFW-1:0] b_q [3];
	logic signed [SUMW-1:0] sx_q;
	logic signed [W-1:0]    n_q [3];

	// Unpacked coordinates of the incoming word
	logic signed [W-1:0]    c_w [3];
	logic signed [W-1:0]    p0_w [3];
	logic signed [W-1:0]    p1_w [3];
	logic signed [W-1:0]    n_w [3];
	logic signed [DIFW-1:0] a_w [3];
	logic signed [DIFW-1:0] b_w [3];
	logic signed [SUMW-1:0] sx_w;

	// Shared multiplier and accumulate adder
	logic signed [W+1:0]   op_a;
	logic signed [DAW-1:0] op_b;
	logic signed [PW-1:0]  prod_q;
	logic signed [PW-1:0]  cap_base, cap_sum;
	logic                  cap_sub;
	logic signed [DAW-1:0] da_q [3];
	logic signed [PW-1:0]  pv_q, dot_q;

	// Divide and sign
	logic                 div_start, div_done;
	logic [PW-1:0]        pv_mag, div_in, div_quot;
	logic [PW+VOL_BITS-1:0] q_ext;
	vol_t                 q64;
	logic                 dot_pos, flip;
	vol_t                 delta_q;

	// Volume store
	vol_t vol_mem [CELL_COUNT];
	vol_t rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	vol_t          mem_wd;
	logic [AW+IDX_BITS-1:0] l_ext, r_ext;
	logic [AW-1:0] l_addr, r_addr;
	logic          in_l, in_r;
	vol_t          addend;
	logic signed [VOL_BITS:0] sum_w;
	vol_t          sat_sum;
	vol_t          lv_q, rv_q;

	// Unpack the incoming coordinates
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			c_w[k]  = $signed(face_center[k*W +: W]);
			p0_w[k] = $signed(node0_pos[k*W +: W]);
			p1_w[k] = $signed(node1_pos[k*W +: W]);
			n_w[k]  = $signed(face_normal[k*W +: W]);
			a_w[k]  = DIFW'(c_w[k]) - DIFW'(p0_w[k]);
			b_w[k]  = DIFW'(c_w[k]) - DIFW'(p1_w[k]);
		end
		sx_w = SUMW'(c_w[0]) + SUMW'(p0_w[0]) + SUMW'(p1_w[0]);
	end

	// Operand select for the multiplier pass in flight
	always_comb begin
		case (step_q)
			MS_DA0_P: begin op_a = (W+2)'(a_q[1]); op_b = DAW'(b_q[2]); end
			MS_DA0_N: begin op_a = (W+2)'(a_q[2]); op_b = DAW'(b_q[1]); end
			MS_DA1_P: begin op_a = (W+2)'(a_q[2]); op_b = DAW'(b_q[0]); end
			MS_DA1_N: begin op_a = (W+2)'(a_q[0]); op_b = DAW'(b_q[2]); end
			MS_DA2_P: begin op_a = (W+2)'(a_q[0]); op_b = DAW'(b_q[1]); end
			MS_DA2_N: begin op_a = (W+2)'(a_q[1]); op_b = DAW'(b_q[0]); end
			MS_VOL:   begin op_a = sx_q;           op_b = da_q[0];      end
			MS_DOT0:  begin op_a = (W+2)'(n_q[0]); op_b = da_q[0];      end
			MS_DOT1:  begin op_a = (W+2)'(n_q[1]); op_b = da_q[1];      end
			MS_DOT2:  begin op_a = (W+2)'(n_q[2]); op_b = da_q[2];      end
			default:  begin op_a = '0;             op_b = '0;           end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	// Accumulate the product of the previous pass
	always_comb begin
		cap_base = '0;
		cap_sub  = 1'b0;
		case (cap_q)
			MS_DA0_N: begin cap_base = PW'(da_q[0]); cap_sub = 1'b1; end
			MS_DA1_N: begin cap_base = PW'(da_q[1]); cap_sub = 1'b1; end
			MS_DA2_N: begin cap_base = PW'(da_q[2]); cap_sub = 1'b1; end
			MS_DOT1, MS_DOT2: cap_base = dot_q;
			default: ;
		endcase
		cap_sum = cap_base + (cap_sub ? -prod_q : prod_q);
	end

	always_ff @(posedge clk) begin
		if (cap_v_q) begin
			case (cap_q)
				MS_DA0_P, MS_DA0_N: da_q[0] <= cap_sum[DAW-1:0];
				MS_DA1_P, MS_DA1_N: da_q[1] <= cap_sum[DAW-1:0];
				MS_DA2_P, MS_DA2_N: da_q[2] <= cap_sum[DAW-1:0];
				MS_VOL:             pv_q    <= cap_sum;
				MS_DOT0, MS_DOT1, MS_DOT2: dot_q <= cap_sum;
				default: ;
			endcase
		end
	end

	// |sum_x * dA.x| + 3, divided by six, rounds half away from zero
	assign pv_mag    = pv_q[PW-1] ? PW'(-pv_q) : PW'(pv_q);
	assign div_in    = PW'(pv_mag + PW'(ROUND_BIAS));
	assign div_start = (state_q == ST_MUL) && (step_q == MS_LAST);

	cvfa_div6 #(
		.WIDTH (PW)
	) u_div6 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign q_ext   = (PW+VOL_BITS)'(div_quot);
	assign q64     = q_ext[VOL_BITS-1:0];
	assign dot_pos = !dot_q[PW-1] && (dot_q != '0);
	assign flip    = sx_q[SUMW-1] ^ da_q[0][DAW-1] ^ !dot_pos;

	// Cell addresses and range checks
	assign l_ext  = (AW+IDX_BITS)'(left_q);
	assign r_ext  = (AW+IDX_BITS)'(right_q);
	assign l_addr = l_ext[AW-1:0];
	assign r_addr = r_ext[AW-1:0];
	assign in_l   = 32'(left_q) < 32'(CELL_COUNT);
	assign in_r   = 32'(right_q) < 32'(CELL_COUNT);

	// Saturating update of the word just read
	assign addend  = (state_q == ST_UP_R) ? -delta_q : delta_q;
	assign sum_w   = {rd_q[VOL_BITS-1], rd_q} + {addend[VOL_BITS-1], addend};
	assign sat_sum = (sum_w[VOL_BITS] != sum_w[VOL_BITS-1])
		? (sum_w[VOL_BITS] ? VOL_MIN : VOL_MAX) : sum_w[VOL_BITS-1:0];

	// Store port select
	always_comb begin
		mem_we = 1'b0;
		mem_wa = l_addr;
		mem_wd = sat_sum;
		case (state_q)
			ST_CLEAR: begin mem_we = 1'b1; mem_wa = clr_q; mem_wd = '0; end
			ST_UP_L:  mem_we = in_l;
			ST_UP_R:  begin mem_we = in_r; mem_wa = r_addr; end
			default: ;
		endcase
	end
	assign mem_ra = (state_q == ST_RD_L) ? l_addr : r_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vol_mem[mem_wa] <= mem_wd;
		end
		rd_q <= vol_mem[mem_ra];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= MS_DA0_P;
			cap_q   <= MS_DA0_P;
			cap_v_q <= 1'b0;
			clr_q   <= '0;
		end else begin
			cap_v_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == AW'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
						step_q  <= MS_DA0_P;
					end
				end
				ST_MUL: begin
					cap_q   <= step_q;
					cap_v_q <= (step_q != MS_LAST);
					if (step_q != MS_LAST) begin
						step_q <= mul_step_t'(step_q + 1'b1);
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_RD_L;
					end
				end
				ST_RD_L: state_q <= ST_UP_L;
				ST_UP_L: state_q <= (bnd_q || !in_r) ? ST_DONE : ST_RD_R;
				ST_RD_R: state_q <= ST_UP_R;
				ST_UP_R: state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Word capture and result registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			bnd_q   <= is_boundary;
			left_q  <= left_cell;
			right_q <= right_cell;
			a_q     <= a_w;
			b_q     <= b_w;
			sx_q    <= sx_w;
			n_q     <= n_w;
		end
		if (div_done) begin
			delta_q <= flip ? -q64 : q64;
		end
		if (state_q == ST_UP_L) begin
			lv_q <= in_l ? sat_sum : '0;
			if (bnd_q || !in_r) begin
				rv_q <= '0;
			end
		end
		if (state_q == ST_UP_R) begin
			rv_q <= sat_sum;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = (state_q == ST_DONE);
	assign left_volume  = lv_q;
	assign right_volume = rv_q;

endmodule

FILE: src/cvfa_checker.sv
`timescale 1ns / 1ps

module cvfa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input logic           is_boundary,
	input cvfa_pkg::vol_t right_volume
);
	import cvfa_pkg::*;

	// Boundary flag of the word in flight
	logic bnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_q <= 1'b0;
		end else if (start && !busy) begin
			bnd_q <= is_boundary;
		end
	end

	// A result only appears while a word is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without a word in flight");

	// A result is one cycle long
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// An accepted word keeps the block busy and gives no result right away
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("block not busy after accepting a word");

	// Boundary facets leave the right volume at zero
	a_bnd_right: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bnd_q) |-> (right_volume == '0))
		else $error("right volume nonzero on a boundary facet");

endmodule

bind cell_volume_facet_accumulator cvfa_checker u_cvfa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.is_boundary  (is_boundary),
	.right_volume (right_volume)
);

FILE: dv/cell_volume_facet_accumulator_test.sv
`timescale 1ns / 1ps

module cell_volume_facet_accumulator_test;
	import cvfa_pkg::*;

	localparam int CELLS        = 1024;
	localparam int COORD_W      = 16;
	localparam int POS_W        = 3 * COORD_W;
	localparam int WATCHDOG_MAX = 20000;
	localparam int DRAIN_CYCLES = 80;
	localparam int MAX_REPORTS  = 10;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                done;
	logic                is_boundary;
	logic [IDX_BITS-1:0] left_cell;
	logic [IDX_BITS-1:0] right_cell;
	logic [POS_W-1:0]    face_center;
	logic [POS_W-1:0]    node0_pos;
	logic [POS_W-1:0]    node1_pos;
	logic [POS_W-1:0]    face_normal;
	vol_t                left_volume;
	vol_t                right_volume;

	// Mirror of the volume store and the volumes still to come out
	vol_t cell_vol_model [0:CELLS-1];
	vol_t pending_left [$];
	vol_t pending_right [$];

	int n_facets;
	int n_boundary;
	int n_shared;
	int n_checked;
	int n_mismatch;
	int idle_cycles;

	cell_volume_facet_accumulator #(
		.CELL_COUNT(CELLS),
		.COORD_BITS(COORD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.is_boundary(is_boundary),
		.left_cell(left_cell),
		.right_cell(right_cell),
		.face_center(face_center),
		.node0_pos(node0_pos),
		.node1_pos(node1_pos),
		.face_normal(face_normal),
		.left_volume(left_volume),
		.right_volume(right_volume)
	);

	always #5 clk = ~clk;

	function automatic logic [POS_W-1:0] pack3(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z);
		return {z, y, x};
	endfunction

	// Signed volume change for the left cell: dV with the sign of dA . normal
	function automatic vol_t facet_delta(input logic [POS_W-1:0] fc, input logic [POS_W-1:0] n0,
			input logic [POS_W-1:0] n1, input logic [POS_W-1:0] nrm);
		longint c [3];
		longint p0 [3];
		longint p1 [3];
		longint nv [3];
		longint a [3];
		longint b [3];
		longint da [3];
		longint sx;
		longint dot;
		longint unsigned ma;
		longint unsigned mb;
		longint unsigned q;
		vol_t dv;
		for (int k = 0; k < 3; k++) begin
			c[k]  = longint'($signed(fc[k*COORD_W +: COORD_W]));
			p0[k] = longint'($signed(n0[k*COORD_W +: COORD_W]));
			p1[k] = longint'($signed(n1[k*COORD_W +: COORD_W]));
			nv[k] = longint'($signed(nrm[k*COORD_W +: COORD_W]));
			a[k]  = c[k] - p0[k];
			b[k]  = c[k] - p1[k];
		end
		da[0] = a[1] * b[2] - a[2] * b[1];
		da[1] = a[2] * b[0] - a[0] * b[2];
		da[2] = a[0] * b[1] - a[1] * b[0];
		sx = c[0] + p0[0] + p1[0];
		// magnitudes stay well inside 64 bits, so round half away from zero directly
		ma = (sx < 0) ? -sx : sx;
		mb = (da[0] < 0) ? -da[0] : da[0];
		q  = (ma * mb + 3) / 6;
		dv = ((sx < 0) != (da[0] < 0)) ? -vol_t'(q) : vol_t'(q);
		dot = da[0] * nv[0] + da[1] * nv[1] + da[2] * nv[2];
		return (dot > 0) ? dv : -dv;
	endfunction

	function automatic vol_t sat_add(input vol_t x, input vol_t y);
		logic signed [VOL_BITS:0] s;
		s = $signed({x[VOL_BITS-1], x}) + $signed({y[VOL_BITS-1], y});
		if (s[VOL_BITS] != s[VOL_BITS-1])
			return s[VOL_BITS] ? VOL_MIN : VOL_MAX;
		return s[VOL_BITS-1:0];
	endfunction

	// Idle gap before a word: mostly short, a few long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3, 4: return 16'($urandom_range(0, 128)) - 16'd64;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [POS_W-1:0] rand_point();
		if ($urandom_range(0, 4) == 0)
			return {16'($urandom), 32'($urandom)};
		return pack3(rand_coord(), rand_coord(), rand_coord());
	endfunction

	// Hand over one facet word; returns once busy is seen low again, start still high
	task automatic send_facet(input logic bnd, input logic [IDX_BITS-1:0] lc,
			input logic [IDX_BITS-1:0] rc, input logic [POS_W-1:0] fc,
			input logic [POS_W-1:0] n0, input logic [POS_W-1:0] n1,
			input logic [POS_W-1:0] nrm);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		is_boundary <= bnd;
		left_cell   <= lc;
		right_cell  <= rc;
		face_center <= fc;
		node0_pos   <= n0;
		node1_pos   <= n1;
		face_normal <= nrm;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	// Facet with sum_x = s and dA.x = dax, to steer the divide-by-six rounding
	task automatic send_rounding_facet(input int s, input int dax, input logic [15:0] nx,
			input logic [IDX_BITS-1:0] lc, input logic [IDX_BITS-1:0] rc);
		send_facet(1'b0, lc, rc, pack3(16'(s), 16'd0, 16'd0), pack3(16'd0, 16'(-dax), 16'd0),
			pack3(16'd0, 16'd0, 16'hFFFF), pack3(nx, 16'd0, 16'd0));
	endtask

	task automatic send_random_facet(input bit hot);
		logic [IDX_BITS-1:0] lc;
		logic [IDX_BITS-1:0] rc;
		logic [IDX_BITS-1:0] hot_cells [4];
		logic [POS_W-1:0] nrm;
		hot_cells = '{10'd3, 10'd512, 10'd777, 10'd1023};
		lc = hot ? hot_cells[$urandom_range(0, 3)] : IDX_BITS'($urandom);
		rc = hot ? hot_cells[$urandom_range(0, 3)] : IDX_BITS'($urandom);
		if ($urandom_range(0, 9) == 0) rc = lc;
		nrm = ($urandom_range(0, 9) == 0) ? '0 : rand_point();
		send_facet($urandom_range(0, 4) == 0, lc, rc, rand_point(), rand_point(),
			rand_point(), nrm);
	endtask

	// Zero, full-scale and mixed-sign coordinates, both first and last cell
	task automatic test_corner_facets();
		send_facet(1'b0, 10'd0, 10'd1023, '0, '0, '0, '0);
		send_facet(1'b0, 10'd0, 10'd1023, pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
			pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
			pack3(16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_facet(1'b0, 10'd1023, 10'd0, pack3(16'h8000, 16'h8000, 16'h8000),
			pack3(16'h8000, 16'h8000, 16'h8000), pack3(16'h8000, 16'h8000, 16'h8000),
			pack3(16'h8000, 16'h8000, 16'h8000));
		// largest |dA.x| with the most negative coordinate sum, both normal signs
		send_facet(1'b0, 10'd1, 10'd2, pack3(16'h8000, 16'h7FFF, 16'h7FFF),
			pack3(16'h8000, 16'h8000, 16'h7FFF), pack3(16'h8000, 16'h7FFF, 16'h8000),
			pack3(16'h7FFF, 16'h0000, 16'h0000));
		send_facet(1'b0, 10'd1, 10'd2, pack3(16'h8000, 16'h7FFF, 16'h7FFF),
			pack3(16'h8000, 16'h8000, 16'h7FFF), pack3(16'h8000, 16'h7FFF, 16'h8000),
			pack3(16'h8000, 16'h8000, 16'h8000));
		send_facet(1'b0, 10'd2, 10'd1, pack3(16'h7FFF, 16'h8000, 16'h8000),
			pack3(16'h7FFF, 16'h7FFF, 16'h8000), pack3(16'h7FFF, 16'h8000, 16'h7FFF),
			pack3(16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_facet(1'b0, 10'd5, 10'd6, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000,
			48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555);
	endtask

	// Ties, round up/down, and a zero dot product
	task automatic test_rounding_and_sign();
		send_rounding_facet(1, 3, 16'd1, 10'd10, 10'd11);
		send_rounding_facet(-1, 3, 16'd1, 10'd10, 10'd11);
		send_rounding_facet(1, 2, 16'd1, 10'd12, 10'd13);
		send_rounding_facet(1, 4, 16'd1, 10'd12, 10'd13);
		send_rounding_facet(-1, 4, 16'hFFFF, 10'd14, 10'd15);
		send_rounding_facet(-1, 2, 16'hFFFF, 10'd14, 10'd15);
		send_rounding_facet(5, 3, 16'd1, 10'd16, 10'd17);
		// zero normal: dot is zero, left cell gets -dV
		send_rounding_facet(3, 5, 16'd0, 10'd16, 10'd17);
		send_facet(1'b0, 10'd16, 10'd17, pack3(16'h0100, 16'h0000, 16'h0000),
			pack3(16'h0000, 16'hFF00, 16'h0000), pack3(16'h0000, 16'h0000, 16'hFF00), '0);
	endtask

	// Boundary facets and a cell on both sides of a facet
	task automatic test_shared_cells();
		send_facet(1'b1, 10'd20, 10'd21, pack3(16'h0200, 16'h0100, 16'h0000),
			pack3(16'h0000, 16'hFF00, 16'h0100), pack3(16'hFF00, 16'h0000, 16'hFF00),
			pack3(16'h0100, 16'h0100, 16'h0100));
		// the right cell of a boundary facet must stay untouched
		send_facet(1'b0, 10'd22, 10'd21, pack3(16'h0300, 16'h0000, 16'h0000),
			pack3(16'h0000, 16'hFE00, 16'h0000), pack3(16'h0000, 16'h0000, 16'hFE00),
			pack3(16'h0100, 16'h0000, 16'h0000));
		send_facet(1'b1, 10'd20, 10'd20, pack3(16'h0200, 16'h0100, 16'h0000),
			pack3(16'h0000, 16'hFF00, 16'h0100), pack3(16'hFF00, 16'h0000, 16'hFF00),
			pack3(16'hFF00, 16'h0000, 16'h0000));
		send_facet(1'b0, 10'd22, 10'd22, pack3(16'h0300, 16'h0000, 16'h0000),
			pack3(16'h0000, 16'hFE00, 16'h0000), pack3(16'h0000, 16'h0000, 16'hFE00),
			pack3(16'h0100, 16'h0000, 16'h0000));
		send_facet(1'b0, 10'd22, 10'd22, pack3(16'h8000, 16'h7FFF, 16'h7FFF),
			pack3(16'h8000, 16'h8000, 16'h7FFF), pack3(16'h8000, 16'h7FFF, 16'h8000),
			pack3(16'h8000, 16'h0000, 16'h0000));
	endtask

	task automatic test_random_facets();
		repeat (1200) send_random_facet(1'b0);
	endtask

	// Few cells, so volumes pile up over many facets
	task automatic test_hot_cells();
		repeat (430) send_random_facet(1'b1);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_left.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input vol_t expected, input vol_t actual);
		if (actual !== expected) begin
			n_mismatch++;
			if (n_mismatch <= MAX_REPORTS)
				$display("mismatch %s: expected %0d (0x%016h) actual %0d (0x%016h)", name,
					expected, expected, actual, actual);
		end
	endtask

	// Predict the store update at each accepted word; every 10-bit index is in range
	always @(posedge clk) begin : predict_volumes
		vol_t d;
		vol_t lv;
		vol_t rv;
		if (arst_n && start && !busy) begin
			d = facet_delta(face_center, node0_pos, node1_pos, face_normal);
			cell_vol_model[left_cell] = sat_add(cell_vol_model[left_cell], d);
			lv = cell_vol_model[left_cell];
			rv = '0;
			if (!is_boundary) begin
				cell_vol_model[right_cell] = sat_add(cell_vol_model[right_cell], -d);
				rv = cell_vol_model[right_cell];
			end
			pending_left.push_back(lv);
			pending_right.push_back(rv);
			n_facets++;
			if (is_boundary) n_boundary++;
			else if (left_cell == right_cell) n_shared++;
		end
	end

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_left.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= MAX_REPORTS)
					$display("unexpected result: left %0d right %0d", left_volume,
						right_volume);
			end else begin
				check_field("left_volume", pending_left.pop_front(), left_volume);
				check_field("right_volume", pending_right.pop_front(), right_volume);
				n_checked++;
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done === 1'b1)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("timeout: no word moved for %0d cycles", WATCHDOG_MAX);
				$display("cell_volume_facet_accumulator_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		foreach (cell_vol_model[i]) cell_vol_model[i] = '0;
		n_facets    = 0;
		n_boundary  = 0;
		n_shared    = 0;
		n_checked   = 0;
		n_mismatch  = 0;
		idle_cycles = 0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		is_boundary <= 1'b0;
		left_cell   <= '0;
		right_cell  <= '0;
		face_center <= '0;
		node0_pos   <= '0;
		node1_pos   <= '0;
		face_normal <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_corner_facets();
		test_rounding_and_sign();
		test_shared_cells();
		test_random_facets();
		test_hot_cells();
		drain_results();

		$display("covered %0d facets: %0d boundary, %0d with one cell on both sides",
			n_facets, n_boundary, n_shared);
		$display("checked %0d result words, %0d mismatches", n_checked, n_mismatch);
		if (n_mismatch == 0)
			$display("cell_volume_facet_accumulator_test: PASS");
		else
			$display("cell_volume_facet_accumulator_test: FAIL");
		$finish;
	end

endmodule
